// ===== rtl/core/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off during reset
`define FFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds in reset
`define FFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/ffa_pkg.sv =====
package ffa_pkg;

  localparam int DEF_MAX_BLOCKS   = 64;
  localparam int DEF_HEADER_BYTES = 24;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [23:0] size;
    logic [31:0] addr;
  } req_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic        active;
    logic        found;
    logic [24:0] start;
  } tok_t;

  typedef struct packed {
    logic        en;
    logic [24:0] start;
    logic [23:0] size;
  } wr_t;

endpackage

// ===== rtl/core/ffa_cell.sv =====
module ffa_cell #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 24,
  parameter int IDX          = 0,
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  ffa_pkg::req_t req,
  input  logic [31:0]   heap_base,
  input  logic [CW-1:0] count,
  input  ffa_pkg::wr_t  wr,
  input  logic [IW-1:0] wr_idx,
  input  ffa_pkg::tok_t tok_in,
  output ffa_pkg::tok_t tok_out
);
  import ffa_pkg::*;

  logic [24:0] start;
  logic [23:0] size;
  logic        is_free;
  logic        live;
  logic        sel;
  logic        hit;
  logic [31:0] uaddr;
  tok_t        tok_next;

  assign live  = CW'(IDX) < count;
  assign sel   = wr.en && (wr_idx == IW'(IDX));
  assign uaddr = heap_base + 32'(start) + 32'(HEADER_BYTES);

  always_comb begin
    hit = 1'b0;
    if (tok_in.active && !tok_in.found && live) begin
      if (req.mode == MODE_ALLOC) begin
        hit = is_free && (size >= req.size);
      end else begin
        hit = (uaddr == req.addr);
      end
    end
    tok_next = tok_in;
    if (hit) begin
      tok_next.found = 1'b1;
      tok_next.start = start;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      start   <= wr.start;
      size    <= wr.size;
      is_free <= 1'b0;
    end else if (hit) begin
      is_free <= (req.mode == MODE_FREE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== rtl/core/first_fit_block_allocator_core.sv =====
// First-fit allocator over a table of up to MAX_BLOCKS blocks held in a row of
// cells. An allocate or free request is worked by a scan token that steps
// through one cell per clock; zero-size allocates and null frees skip the
// scan and go straight to the result. One request is worked at a time; a new
// one is accepted while the previous result still waits on the output.
// heap_base and heap_limit are to be written over the APB port only while no
// request is in flight; the block itself does not enforce this.
module first_fit_block_allocator_core #(
  parameter int MAX_BLOCKS   = ffa_pkg::DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [23:0] request_size,
  input  logic [31:0] user_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] granted_address,
  output logic [1:0]  status
);
  import ffa_pkg::*;
  `include "assert_macros.svh"

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state;
  logic [31:0]   heap_base;
  logic [24:0]   heap_limit;
  logic [CW-1:0] count;
  logic [24:0]   brk;
  req_t          req;
  logic          inject;
  logic [31:0]   res_addr;
  logic [1:0]    res_status;
  wr_t           wr;
  tok_t          tok_w [MAX_BLOCKS+1];
  tok_t          tail;
  logic [25:0]   new_break;
  logic          in_acc;
  logic          out_load;

  assign pready   = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  always_comb begin
    case (paddr[2])
      REG_HEAP_BASE:  prdata = heap_base;
      REG_HEAP_LIMIT: prdata = {7'd0, heap_limit};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= 32'd65536;
      heap_limit <= 25'd16777216;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_HEAP_BASE:  heap_base  <= pwdata;
        REG_HEAP_LIMIT: heap_limit <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  assign tok_w[0] = '{active: inject, found: 1'b0, start: 25'd0};
  assign tail     = tok_w[MAX_BLOCKS];

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    ffa_cell #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .HEADER_BYTES(HEADER_BYTES),
      .IDX         (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .req      (req),
      .heap_base(heap_base),
      .count    (count),
      .wr       (wr),
      .wr_idx   (count[IW-1:0]),
      .tok_in   (tok_w[i]),
      .tok_out  (tok_w[i+1])
    );
  end

  assign new_break = 26'(brk) + 26'(req.size) + 26'(HEADER_BYTES);

  always_comb begin
    wr       = '{en: 1'b0, start: brk, size: req.size};
    if ((state == S_SCAN) && tail.active && !tail.found && (req.mode == MODE_ALLOC) &&
        (count < CW'(MAX_BLOCKS)) && (new_break <= 26'(heap_limit))) begin
      wr.en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      inject    <= 1'b0;
      count     <= '0;
      brk       <= '0;
      out_valid <= 1'b0;
    end else begin
      // zero-size allocates and null frees skip the scan
      inject <= in_acc && !((mode == MODE_ALLOC) && (request_size == 24'd0)) &&
                !((mode == MODE_FREE) && (user_address == 32'd0));
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            req <= '{mode: mode, size: request_size, addr: user_address};
            res_addr <= 32'd0;
            if (mode == MODE_ALLOC && request_size == 24'd0) begin
              res_status <= ST_ZERO;
              state      <= S_FIN;
            end else if (mode == MODE_FREE && user_address == 32'd0) begin
              res_status <= ST_OK;
              state      <= S_FIN;
            end else begin
              state  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (tail.active) begin
            state <= S_FIN;
            if (req.mode == MODE_FREE) begin
              res_addr   <= 32'd0;
              res_status <= tail.found ? ST_OK : ST_UNKNOWN;
            end else if (tail.found) begin
              res_addr   <= heap_base + 32'(tail.start) + 32'(HEADER_BYTES);
              res_status <= ST_OK;
            end else if (wr.en) begin
              res_addr   <= heap_base + 32'(brk) + 32'(HEADER_BYTES);
              res_status <= ST_OK;
              count      <= count + 1'b1;
              brk        <= new_break[24:0];
            end else begin
              res_addr   <= 32'd0;
              res_status <= ST_NOSPACE;
            end
          end
        end
        S_FIN: begin
          if (out_load) begin
            granted_address <= res_addr;
            status          <= res_status;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FFA_ASSERT(a_count_cap, count <= CW'(MAX_BLOCKS), "block count past table size")
  `FFA_ASSERT(a_tail_scan, tail.active |-> state == S_SCAN, "scan token out of scan")
  `FFA_ASSERT(a_append_cnt, wr.en |=> count == $past(count) + 1'b1, "append lost count")
  `FFA_ASSERT(a_inject_one, inject |=> !inject, "second token injected")

endmodule
